// ===== src/assert_macros.svh =====
// Assertion macros shared by the card table RTL.
// Clocked on clock, disabled while reset is high; no other dependencies.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication: consequent must hold whenever the antecedent does
`define ACCT_ASSERT(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error("acct assertion failed");

// Next-cycle implication: consequent must hold in the cycle after the antecedent
`define ACCT_ASSERT_NEXT(lbl, ante, cons) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error("acct assertion failed");

`endif

// ===== src/acct_pkg.sv =====
// Shared types and constants for the access card table.
// No dependencies; used by the channel interfaces and the top level.
`default_nettype none

package acct_pkg;

   // Default table geometry
   localparam int DEF_TABLE_ENTRIES = 64;
   localparam int DEF_KEY_BYTES     = 7;

   // Fixed field widths
   localparam int CARD_KEY_W = 56;
   localparam int REC_KEY_W  = CARD_KEY_W + 1;
   localparam int SLOT_W     = 6;

   // Record mark bit positions
   localparam int FLAG_USER  = 0;
   localparam int FLAG_MAINT = 1;
   localparam int FLAG_GONE  = 2;

   typedef enum logic [1:0] {
      REQ_LOOKUP     = 2'd0,
      REQ_STORE      = 2'd1,
      REQ_REVALIDATE = 2'd2,
      REQ_PURGE      = 2'd3
   } req_kind_type;

   typedef enum logic [1:0] {
      VERDICT_REVOKED = 2'd0,
      VERDICT_USER    = 2'd1,
      VERDICT_MAINT   = 2'd2,
      VERDICT_KEEP    = 2'd3
   } verdict_type;

   typedef enum logic [2:0] {
      OUT_NONE      = 3'd0,
      OUT_UPDATED   = 3'd1,
      OUT_ADDED     = 3'd2,
      OUT_FULL      = 3'd3,
      OUT_WITHDRAWN = 3'd4,
      OUT_PROMOTED  = 3'd5,
      OUT_DEMOTED   = 3'd6,
      OUT_RSVD      = 3'd7
   } outcome_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_SCAN,
      ST_DECIDE
   } state_type;

   typedef struct packed {
      logic [1:0]            req_type;
      logic [CARD_KEY_W-1:0] card_key;
      logic                  key_is_long;
      logic                  grant_user;
      logic                  grant_maintainer;
      logic [1:0]            verdict;
   } req_payload_type;

   typedef struct packed {
      logic              hit;
      logic              rec_user;
      logic              rec_maintainer;
      logic [SLOT_W-1:0] slot;
      logic [2:0]        outcome;
   } rsp_payload_type;

   // One table entry: long flag and key, then the three marks
   typedef struct packed {
      logic [REC_KEY_W-1:0] key;
      logic [2:0]           flags;
   } record_type;

endpackage

`default_nettype wire

// ===== src/acct_if.sv =====
// Valid/ready channel interfaces for card table requests and results.
// Depends on acct_pkg for the payload types.
`default_nettype none

interface acct_req_if;
   logic                     valid;
   logic                     ready;
   acct_pkg::req_payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

interface acct_rsp_if;
   logic                     valid;
   logic                     ready;
   acct_pkg::rsp_payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink   (input valid, input payload, output ready);
endinterface

`default_nettype wire

// ===== src/access_card_cache_table.sv =====
// Card record table top level; uses acct_pkg, acct_if.sv and assert_macros.svh.
// A lookup, store or revalidate is accepted in idle, scans the filled slots in order through the
// registered read port, then forms its result in the decide state; a hit ends the scan early.
// Purge skips the scan. The decide state waits while the output still holds the last result.
// One request at a time, taken in idle after the result loads; the single read port sets this.
// Reset clears only the fill count and control; the record memory is not cleared.
`default_nettype none

module access_card_cache_table #(
   parameter int TABLE_ENTRIES = acct_pkg::DEF_TABLE_ENTRIES,
   parameter int KEY_BYTES     = acct_pkg::DEF_KEY_BYTES
) (
   input  wire logic   clock,
   input  wire logic   reset,
   acct_req_if.sink    req,
   acct_rsp_if.source  rsp
);

   localparam int AW       = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
   localparam int FW       = $clog2(TABLE_ENTRIES + 1);
   localparam int KEY_BITS = (KEY_BYTES * 8 >= acct_pkg::CARD_KEY_W) ?
                             acct_pkg::CARD_KEY_W : KEY_BYTES * 8;
   localparam logic [acct_pkg::CARD_KEY_W-1:0] KEY_MASK =
      {acct_pkg::CARD_KEY_W{1'b1}} >> (acct_pkg::CARD_KEY_W - KEY_BITS);
   localparam logic [FW-1:0] FILL_MAX = FW'(TABLE_ENTRIES);

   // Record memory
   acct_pkg::record_type rec_mem [TABLE_ENTRIES];

   acct_pkg::state_type             state_ff, state_in;
   logic [FW-1:0]                   fill_count_ff, fill_count_in;
   logic [1:0]                      req_type_ff, req_type_in;
   logic [acct_pkg::REC_KEY_W-1:0]  req_key_ff, req_key_in;
   logic [1:0]                      want_ff, want_in;
   logic [1:0]                      verdict_ff, verdict_in;
   logic [FW-1:0]                   issue_ff, issue_in;
   logic                            chk_valid_ff, chk_valid_in;
   logic [AW-1:0]                   chk_idx_ff, chk_idx_in;
   acct_pkg::record_type            rd_data_ff;
   logic                            found_ff, found_in;
   logic [AW-1:0]                   found_idx_ff, found_idx_in;
   logic [2:0]                      found_flags_ff, found_flags_in;
   logic                            gone_found_ff, gone_found_in;
   logic [AW-1:0]                   gone_idx_ff, gone_idx_in;
   logic                            rsp_valid_ff, rsp_valid_in;
   acct_pkg::rsp_payload_type       rsp_data_ff, rsp_data_in;

   logic                            req_ready;
   logic                            rd_en;
   logic                            mem_we;
   logic [AW-1:0]                   mem_waddr;
   acct_pkg::record_type            mem_wdata;
   logic                            dec_fire;
   acct_pkg::rsp_payload_type       res;

   assign req.ready   = req_ready;
   assign rsp.valid   = rsp_valid_ff;
   assign rsp.payload = rsp_data_ff;

   // Next state, scan control, decision and write-back
   always_comb begin
      state_in       = state_ff;
      fill_count_in  = fill_count_ff;
      req_type_in    = req_type_ff;
      req_key_in     = req_key_ff;
      want_in        = want_ff;
      verdict_in     = verdict_ff;
      issue_in       = issue_ff;
      chk_valid_in   = chk_valid_ff;
      chk_idx_in     = chk_idx_ff;
      found_in       = found_ff;
      found_idx_in   = found_idx_ff;
      found_flags_in = found_flags_ff;
      gone_found_in  = gone_found_ff;
      gone_idx_in    = gone_idx_ff;
      rsp_valid_in   = rsp_valid_ff && !rsp.ready;
      rsp_data_in    = rsp_data_ff;
      req_ready      = 1'b0;
      rd_en          = 1'b0;
      mem_we         = 1'b0;
      mem_waddr      = found_idx_ff;
      mem_wdata      = '{key: req_key_ff, flags: {1'b0, want_ff}};
      dec_fire       = 1'b0;
      res            = '0;

      unique case (state_ff)
         acct_pkg::ST_IDLE: begin
            req_ready = 1'b1;
            if (req.valid) begin
               req_type_in   = req.payload.req_type;
               req_key_in    = {req.payload.key_is_long, req.payload.card_key & KEY_MASK};
               want_in       = {req.payload.grant_maintainer, req.payload.grant_user};
               verdict_in    = req.payload.verdict;
               issue_in      = '0;
               chk_valid_in  = 1'b0;
               found_in      = 1'b0;
               gone_found_in = 1'b0;
               if (req.payload.req_type == acct_pkg::REQ_PURGE) begin
                  state_in = acct_pkg::ST_DECIDE;
               end else begin
                  state_in = acct_pkg::ST_SCAN;
               end
            end
         end

         acct_pkg::ST_SCAN: begin
            // Issue the next read while the previous one is checked
            if (issue_ff < fill_count_ff) begin
               rd_en        = 1'b1;
               chk_valid_in = 1'b1;
               chk_idx_in   = issue_ff[AW-1:0];
               issue_in     = issue_ff + FW'(1);
            end else begin
               chk_valid_in = 1'b0;
            end
            if (chk_valid_ff) begin
               if (!rd_data_ff.flags[acct_pkg::FLAG_GONE] && rd_data_ff.key == req_key_ff) begin
                  found_in       = 1'b1;
                  found_idx_in   = chk_idx_ff;
                  found_flags_in = rd_data_ff.flags;
                  chk_valid_in   = 1'b0;
                  state_in       = acct_pkg::ST_DECIDE;
               end else if (rd_data_ff.flags[acct_pkg::FLAG_GONE] && !gone_found_ff) begin
                  gone_found_in = 1'b1;
                  gone_idx_in   = chk_idx_ff;
               end
            end else if (issue_ff == fill_count_ff) begin
               state_in = acct_pkg::ST_DECIDE;
            end
         end

         acct_pkg::ST_DECIDE: begin
            // Form the result and the write-back
            if (req_type_ff == acct_pkg::REQ_PURGE) begin
               res = '0;
            end else if (found_ff) begin
               res.hit            = 1'b1;
               res.slot           = acct_pkg::SLOT_W'(found_idx_ff);
               res.rec_user       = found_flags_ff[acct_pkg::FLAG_USER];
               res.rec_maintainer = found_flags_ff[acct_pkg::FLAG_MAINT];
               res.outcome        = acct_pkg::OUT_NONE;
               mem_wdata.flags    = found_flags_ff;
               case (req_type_ff)
                  acct_pkg::REQ_STORE: begin
                     if (found_flags_ff[1:0] != want_ff) begin
                        mem_we             = 1'b1;
                        mem_wdata.flags    = {1'b0, want_ff};
                        res.rec_user       = want_ff[0];
                        res.rec_maintainer = want_ff[1];
                        res.outcome        = acct_pkg::OUT_UPDATED;
                     end
                  end
                  acct_pkg::REQ_REVALIDATE: begin
                     if (verdict_ff == acct_pkg::VERDICT_REVOKED) begin
                        mem_we          = 1'b1;
                        mem_wdata.flags = found_flags_ff | 3'b100;
                        res.outcome     = acct_pkg::OUT_WITHDRAWN;
                     end else if (verdict_ff == acct_pkg::VERDICT_MAINT &&
                                  !found_flags_ff[acct_pkg::FLAG_MAINT]) begin
                        mem_we             = 1'b1;
                        mem_wdata.flags    = found_flags_ff | 3'b010;
                        res.rec_maintainer = 1'b1;
                        res.outcome        = acct_pkg::OUT_PROMOTED;
                     end else if (verdict_ff == acct_pkg::VERDICT_USER &&
                                  found_flags_ff[acct_pkg::FLAG_MAINT]) begin
                        mem_we             = 1'b1;
                        mem_wdata.flags    = found_flags_ff & 3'b101;
                        res.rec_maintainer = 1'b0;
                        res.outcome        = acct_pkg::OUT_DEMOTED;
                     end
                  end
                  default: begin
                  end
               endcase
            end else if (req_type_ff == acct_pkg::REQ_STORE) begin
               // Reuse the lowest withdrawn slot, else append, or report full when the table is full
               res.rec_user       = want_ff[0];
               res.rec_maintainer = want_ff[1];
               res.outcome        = acct_pkg::OUT_ADDED;
               if (gone_found_ff) begin
                  mem_we    = 1'b1;
                  mem_waddr = gone_idx_ff;
                  res.slot  = acct_pkg::SLOT_W'(gone_idx_ff);
               end else if (fill_count_ff >= FILL_MAX) begin
                  res = '{hit: 1'b0, rec_user: 1'b0, rec_maintainer: 1'b0, slot: '0,
                          outcome: acct_pkg::OUT_FULL};
               end else begin
                  mem_we    = 1'b1;
                  mem_waddr = fill_count_ff[AW-1:0];
                  res.slot  = acct_pkg::SLOT_W'(fill_count_ff);
               end
            end

            if (!rsp_valid_ff || rsp.ready) begin
               dec_fire     = 1'b1;
               rsp_valid_in = 1'b1;
               rsp_data_in  = res;
               state_in     = acct_pkg::ST_IDLE;
               if (req_type_ff == acct_pkg::REQ_PURGE) begin
                  fill_count_in = '0;
               end else if (!found_ff && req_type_ff == acct_pkg::REQ_STORE &&
                            !gone_found_ff && fill_count_ff < FILL_MAX) begin
                  fill_count_in = fill_count_ff + FW'(1);
               end
            end else begin
               mem_we = 1'b0;
            end
         end

         default: begin
            state_in = acct_pkg::ST_IDLE;
         end
      endcase
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= acct_pkg::ST_IDLE;
         fill_count_ff <= '0;
         chk_valid_ff  <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         state_ff      <= state_in;
         fill_count_ff <= fill_count_in;
         chk_valid_ff  <= chk_valid_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
   end

   // Request and scan payload registers
   always_ff @(posedge clock) begin
      req_type_ff    <= req_type_in;
      req_key_ff     <= req_key_in;
      want_ff        <= want_in;
      verdict_ff     <= verdict_in;
      issue_ff       <= issue_in;
      chk_idx_ff     <= chk_idx_in;
      found_ff       <= found_in;
      found_idx_ff   <= found_idx_in;
      found_flags_ff <= found_flags_in;
      gone_found_ff  <= gone_found_in;
      gone_idx_ff    <= gone_idx_in;
      rsp_data_ff    <= rsp_data_in;
   end

   // Record memory: one write port, one registered read port
   always_ff @(posedge clock) begin
      if (mem_we) begin
         rec_mem[mem_waddr] <= mem_wdata;
      end
      if (rd_en) begin
         rd_data_ff <= rec_mem[issue_ff[AW-1:0]];
      end
   end

`include "assert_macros.svh"

   // Every checked slot lies below the fill count
   `ACCT_ASSERT(a_chk_range, chk_valid_ff, FW'(chk_idx_ff) < fill_count_ff)
   // A finished decision loads the result register
   `ACCT_ASSERT_NEXT(a_rsp_load, dec_fire, rsp_valid_ff)
   // An append grows the table by one entry
   `ACCT_ASSERT_NEXT(a_append, dec_fire && res.outcome == acct_pkg::OUT_ADDED && !gone_found_ff,
                     fill_count_ff == $past(fill_count_ff) + FW'(1))
   // No new request enters while the scan or decision is in flight
   `ACCT_ASSERT(a_one_at_a_time, state_ff != acct_pkg::ST_IDLE, !req_ready)

endmodule

`default_nettype wire
